FILE: sv/sia_pkg.sv
// shared types, constants and codes for the shift-insert array
`timescale 1ns / 1ps

package sia_pkg;

  // array geometry
  localparam int DEPTH = 256;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  // port field widths
  localparam int FUNC_W   = 3;
  localparam int INDEX_W  = 9;
  localparam int STATUS_W = 2;
  localparam int WORD_W   = 64;

  // read select tree split: low bits pick inside a group, high bits pick the group
  localparam int LO_W  = (IDX_W + 1) / 2;
  localparam int HI_W  = IDX_W - LO_W;
  localparam int GRP   = 2 ** LO_W;
  localparam int NGRP  = 2 ** HI_W;

  // bit pattern of -1.0 in double precision
  localparam logic [WORD_W-1:0] NEG_ONE_BITS = 64'hBFF0_0000_0000_0000;

  typedef logic [WORD_W-1:0] word_t;

  // operation codes
  typedef enum logic [FUNC_W-1:0] {
    F_GET   = 3'd0,
    F_SET   = 3'd1,
    F_INS   = 3'd2,
    F_ERA   = 3'd3,
    F_PUSH  = 3'd4,
    F_POP   = 3'd5,
    F_CLEAR = 3'd6,
    F_FILL  = 3'd7
  } func_t;

  // status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_BOUNDS = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  // command broadcast to every cell
  typedef enum logic [2:0] {
    CMD_NONE = 3'd0,
    CMD_SET  = 3'd1,
    CMD_INS  = 3'd2,
    CMD_ERA  = 3'd3,
    CMD_FILL = 3'd4
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t          op;
    logic [CNT_W-1:0] pos;
  } cell_cmd_t;

endpackage

FILE: sv/sia_cell.sv
// one storage cell of the array: holds a word and trades it with its neighbors
`timescale 1ns / 1ps

module sia_cell (
  input  logic                     clk,
  input  sia_pkg::cell_cmd_t       cmd,
  input  logic [sia_pkg::IDX_W-1:0] cell_pos,
  input  sia_pkg::word_t           value,
  input  sia_pkg::word_t           left_entry,
  input  sia_pkg::word_t           right_entry,
  output sia_pkg::word_t           entry
);
  import sia_pkg::*;

  word_t            entry_r;
  word_t            entry_nxt;
  logic [CNT_W-1:0] pos_ext;

  assign pos_ext = CNT_W'(cell_pos);

  // pick the next word from the broadcast command and this cell's position
  always_comb begin
    entry_nxt = entry_r;
    case (cmd.op)
      CMD_SET: begin
        if (pos_ext == cmd.pos) entry_nxt = value;
      end
      CMD_INS: begin
        if (pos_ext == cmd.pos) entry_nxt = value;
        else if (pos_ext > cmd.pos) entry_nxt = left_entry;
      end
      CMD_ERA: begin
        if (pos_ext >= cmd.pos) entry_nxt = right_entry;
      end
      CMD_FILL: begin
        if (pos_ext < cmd.pos) entry_nxt = '0;
      end
      default: entry_nxt = entry_r;
    endcase
  end

  // word storage
  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

FILE: sv/sia_rd_sel.sv
// two-level registered read select over the row of cells
`timescale 1ns / 1ps

module sia_rd_sel (
  input  logic                      clk,
  input  logic                      rd_en,
  input  logic [sia_pkg::IDX_W-1:0] rd_addr,
  input  sia_pkg::word_t            ent [sia_pkg::DEPTH],
  output sia_pkg::word_t            rd_data
);
  import sia_pkg::*;

  word_t            grp_r   [NGRP];
  word_t            grp_nxt [NGRP];
  logic [HI_W-1:0]  hi_r;
  logic [LO_W-1:0]  lo_addr;

  assign lo_addr = rd_addr[LO_W-1:0];

  // first level: one word out of each group
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_nxt[g] = '0;
      for (int j = 0; j < GRP; j++) begin
        if ((g * GRP + j < DEPTH) && (lo_addr == LO_W'(j))) begin
          grp_nxt[g] = ent[g * GRP + j];
        end
      end
    end
  end

  // capture group words and group select
  always_ff @(posedge clk) begin
    if (rd_en) begin
      for (int g = 0; g < NGRP; g++) begin
        grp_r[g] <= grp_nxt[g];
      end
      hi_r <= rd_addr[IDX_W-1:LO_W];
    end
  end

  // second level: the chosen group
  assign rd_data = grp_r[hi_r];

endmodule

FILE: sv/shift_insert_array.sv
// top level of the shift-insert array: decode, row of cells, result pipeline
// pipeline: two register stages, stage one and then the output stage
// throughput: one transaction per cycle while the output is not stalled; every shift moves all cells at once
// the read path is a two-level select tree, one level in each of the two stages
// reset: synchronous active-low rst_n empties the array and drops both stages
// stored words are not cleared; only entries below the count are ever read
`timescale 1ns / 1ps

module shift_insert_array (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [sia_pkg::FUNC_W-1:0]    in_func,
  input  logic [sia_pkg::INDEX_W-1:0]   in_index,
  input  logic [sia_pkg::WORD_W-1:0]    in_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [sia_pkg::STATUS_W-1:0]  out_status,
  output logic [sia_pkg::WORD_W-1:0]    out_read_value,
  output logic [sia_pkg::INDEX_W-1:0]   out_count,
  output logic                          out_is_empty
);
  import sia_pkg::*;

  // handshake and pipeline control
  logic in_acc;
  logic s1_adv;
  logic out_adv;

  // live count
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  // decode results
  cell_cmd_t        cmd;
  status_t          status_d;
  logic             is_get_d;
  logic [CNT_W-1:0] idx_ext;

  // stage one
  logic             s1_valid_r;
  status_t          s1_status_r;
  logic             s1_get_r;
  logic [CNT_W-1:0] s1_count_r;

  // output stage
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  word_t               out_read_r;
  logic [CNT_W-1:0]    out_count_r;

  // row of cells
  word_t ent [DEPTH];
  word_t rd_data;

  assign out_adv  = !out_valid_r || !out_stall;
  assign s1_adv   = !s1_valid_r || out_adv;
  assign in_stall = !s1_adv;
  assign in_acc   = in_valid && !in_stall;

  assign idx_ext = CNT_W'(in_index);

  // operation decode against the live count
  always_comb begin
    cmd.op    = CMD_NONE;
    cmd.pos   = idx_ext;
    status_d  = ST_OK;
    is_get_d  = 1'b0;
    count_nxt = count_r;
    case (func_t'(in_func))
      F_GET: begin
        is_get_d = 1'b1;
        if (idx_ext >= count_r) status_d = ST_BOUNDS;
      end
      F_SET: begin
        if (idx_ext < count_r) cmd.op = CMD_SET;
        else status_d = ST_BOUNDS;
      end
      F_INS, F_PUSH: begin
        if (func_t'(in_func) == F_PUSH) cmd.pos = count_r;
        if (cmd.pos > count_r) begin
          status_d = ST_BOUNDS;
        end else if (count_r == CNT_W'(DEPTH)) begin
          status_d = ST_FULL;
        end else begin
          cmd.op    = CMD_INS;
          count_nxt = count_r + 1'b1;
        end
      end
      F_ERA, F_POP: begin
        if (func_t'(in_func) == F_POP) cmd.pos = count_r;
        if (count_r == '0) begin
          status_d = ST_EMPTY;
        end else if (cmd.pos > count_r) begin
          status_d = ST_BOUNDS;
        end else begin
          if (cmd.pos < count_r) cmd.op = CMD_ERA;
          count_nxt = count_r - 1'b1;
        end
      end
      F_CLEAR: begin
        count_nxt = '0;
      end
      F_FILL: begin
        if (idx_ext > CNT_W'(DEPTH)) begin
          status_d = ST_BOUNDS;
        end else begin
          cmd.op    = CMD_FILL;
          count_nxt = idx_ext;
        end
      end
      default: status_d = ST_OK;
    endcase
    if (!in_acc) begin
      cmd.op    = CMD_NONE;
      count_nxt = count_r;
    end
  end

  // the chain of cells
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    word_t left_w;
    word_t right_w;
    if (k == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = ent[k-1];
    end
    if (k == DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = ent[k+1];
    end
    sia_cell u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .cell_pos    (IDX_W'(k)),
      .value       (in_value),
      .left_entry  (left_w),
      .right_entry (right_w),
      .entry       (ent[k])
    );
  end

  // read select, first level captured at accept
  sia_rd_sel u_rd_sel (
    .clk     (clk),
    .rd_en   (in_acc),
    .rd_addr (in_index[IDX_W-1:0]),
    .ent     (ent),
    .rd_data (rd_data)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (s1_adv) s1_valid_r <= in_acc;
      if (out_adv) out_valid_r <= s1_valid_r;
    end
  end

  // stage one payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_status_r <= status_d;
      s1_get_r    <= is_get_d;
      s1_count_r  <= count_nxt;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (out_adv && s1_valid_r) begin
      out_status_r <= s1_status_r;
      out_count_r  <= s1_count_r;
      if (!s1_get_r) out_read_r <= '0;
      else if (s1_status_r == ST_OK) out_read_r <= rd_data;
      else out_read_r <= NEG_ONE_BITS;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_read_value = out_read_r;
  assign out_count      = INDEX_W'(out_count_r);
  assign out_is_empty   = (out_count_r == '0);

  // count never passes the depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("live count above depth");

  // an accepted transaction lands in stage one
  a_acc_to_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> s1_valid_r)
    else $error("accepted transaction lost");

  // a blocked stage one keeps its contents
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> (s1_valid_r && $stable(s1_count_r)))
    else $error("stage one changed while blocked");

  // full is only reported at full depth
  a_full_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_status_r == ST_FULL) |-> (s1_count_r == CNT_W'(DEPTH)))
    else $error("full status below depth");

  // empty status leaves the count at zero
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_status_r == ST_EMPTY) |-> (s1_count_r == '0))
    else $error("empty status with entries present");

endmodule

FILE: sim/tb_shift_insert_array.sv
// self-checking testbench for the shift-insert array with its own array model
`timescale 1ns / 1ps

module tb_shift_insert_array;
  import sia_pkg::*;

  // one result transaction as the block reports it
  typedef struct packed {
    status_t              status;
    word_t                read_value;
    logic [INDEX_W-1:0]   count;
    logic                 is_empty;
  } array_result_t;

  // receiver stall patterns
  typedef enum logic [1:0] {
    RX_READY    = 2'd0,
    RX_RANDOM   = 2'd1,
    RX_PERIODIC = 2'd2,
    RX_HEAVY    = 2'd3
  } rx_pattern_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [FUNC_W-1:0]    in_func;
  logic [INDEX_W-1:0]   in_index;
  logic [WORD_W-1:0]    in_value;
  logic                 out_valid;
  logic                 out_stall;
  logic [STATUS_W-1:0]  out_status;
  logic [WORD_W-1:0]    out_read_value;
  logic [INDEX_W-1:0]   out_count;
  logic                 out_is_empty;

  // shadow copy of the array contents and its live count
  word_t                shadow_words [DEPTH];
  int unsigned          shadow_count;
  array_result_t        pending_results [$];

  int unsigned          mismatch_count;
  rx_pattern_t          rx_pattern;
  int unsigned          rx_tick;
  bit                   tx_gappy;
  int unsigned          burst_left;

  shift_insert_array i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_index       (in_index),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_read_value (out_read_value),
    .out_count      (out_count),
    .out_is_empty   (out_is_empty)
  );

  // clock
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // known values on every input from time zero
  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_func   = F_GET;
    in_index  = '0;
    in_value  = '0;
    out_stall = 1'b0;
  end

  // apply one operation to the shadow array and queue its expected result
  task automatic predict_array_op(input func_t op, input logic [INDEX_W-1:0] idx,
                                  input word_t val);
    int unsigned   k;
    int unsigned   pos;
    array_result_t res;
    res.status     = ST_OK;
    res.read_value = '0;
    pos            = 32'(idx);
    case (op)
      F_GET: begin
        if (pos < shadow_count) res.read_value = shadow_words[pos];
        else begin
          res.status     = ST_BOUNDS;
          res.read_value = NEG_ONE_BITS;
        end
      end
      F_SET: begin
        if (pos < shadow_count) shadow_words[pos] = val;
        else res.status = ST_BOUNDS;
      end
      F_INS, F_PUSH: begin
        if (op == F_PUSH) pos = shadow_count;
        if (pos > shadow_count) res.status = ST_BOUNDS;
        else if (shadow_count >= DEPTH) res.status = ST_FULL;
        else begin
          for (k = shadow_count; k > pos; k--) shadow_words[k] = shadow_words[k-1];
          shadow_words[pos] = val;
          shadow_count++;
        end
      end
      F_ERA, F_POP: begin
        if (op == F_POP) pos = shadow_count;
        if (shadow_count == 0) res.status = ST_EMPTY;
        else if (pos > shadow_count) res.status = ST_BOUNDS;
        else begin
          for (k = pos; k + 1 < shadow_count; k++) shadow_words[k] = shadow_words[k+1];
          shadow_count--;
        end
      end
      F_CLEAR: shadow_count = 0;
      default: begin
        // fill zeros
        if (pos > DEPTH) res.status = ST_BOUNDS;
        else begin
          for (k = 0; k < pos; k++) shadow_words[k] = '0;
          shadow_count = pos;
        end
      end
    endcase
    res.count    = shadow_count[INDEX_W-1:0];
    res.is_empty = (shadow_count == 0);
    pending_results.push_back(res);
  endtask

  // send one transaction, with burst gaps when enabled, and predict it on acceptance
  task automatic send_op(input func_t op, input logic [INDEX_W-1:0] idx,
                         input word_t val);
    int unsigned gap;
    if (tx_gappy && burst_left == 0) begin
      gap = $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
      burst_left = $urandom_range(1, 12);
    end
    if (burst_left != 0) burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_func  <= op;
    in_index <= idx;
    in_value <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_array_op(op, idx, val);
  endtask

  // receiver stall pattern, changed per test phase
  always @(negedge clk) begin
    rx_tick <= rx_tick + 1;
    case (rx_pattern)
      RX_READY:    out_stall <= 1'b0;
      RX_RANDOM:   out_stall <= ($urandom_range(0, 3) == 0);
      RX_PERIODIC: out_stall <= (rx_tick % 5 < 2);
      default:     out_stall <= ($urandom_range(0, 9) < 6);
    endcase
  end

  // compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    array_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: status %0d value %h count %0d empty %0b",
                   out_status, out_read_value, out_count, out_is_empty);
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status || out_read_value !== want.read_value ||
            out_count !== want.count || out_is_empty !== want.is_empty) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"mismatch: exp status %0d value %h count %0d empty %0b, ",
                      "got status %0d value %h count %0d empty %0b"},
                     want.status, want.read_value, want.count, want.is_empty,
                     out_status, out_read_value, out_count, out_is_empty);
        end
      end
    end
  end

  // random 64-bit word with extra weight on the extremes
  function automatic word_t pick_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // index mostly within 0..bound, sometimes anywhere in 0..DEPTH
  function automatic logic [INDEX_W-1:0] pick_index(input int unsigned bound);
    if ($urandom_range(0, 9) == 0) return INDEX_W'($urandom_range(0, DEPTH));
    return INDEX_W'($urandom_range(0, bound));
  endfunction

  // operations on an empty array: every access is rejected, clear still works
  task automatic test_empty_array();
    send_op(F_GET, 9'd0, '0);
    send_op(F_SET, 9'd0, '1);
    send_op(F_ERA, 9'd0, '0);
    send_op(F_POP, 9'd0, '0);
    send_op(F_ERA, 9'd256, '0);
    send_op(F_INS, 9'd1, '1);
    send_op(F_CLEAR, 9'd0, '0);
  endtask

  // insert and erase with shifts, appends at the count, set and get
  task automatic test_shift_ops();
    send_op(F_PUSH, 9'd0, '1);
    send_op(F_PUSH, 9'd0, '0);
    send_op(F_INS, 9'd0, 64'h0123_4567_89ab_cdef);
    send_op(F_INS, 9'd3, 64'hfedc_ba98_7654_3210);
    send_op(F_INS, 9'd1, 64'h5555_aaaa_5555_aaaa);
    send_op(F_GET, 9'd0, '0);
    send_op(F_GET, 9'd4, '0);
    send_op(F_SET, 9'd2, 64'haaaa_5555_aaaa_5555);
    send_op(F_ERA, 9'd1, '0);
    send_op(F_ERA, 9'd4, '0);
    send_op(F_ERA, 9'd5, '0);
    send_op(F_POP, 9'd0, '0);
    send_op(F_GET, 9'd3, '0);
  endtask

  // full array rejections and fill at its limits
  task automatic test_full_and_fill();
    send_op(F_FILL, 9'd256, '0);
    send_op(F_PUSH, 9'd0, '1);
    send_op(F_INS, 9'd256, '1);
    send_op(F_INS, 9'd257, '1);
    send_op(F_GET, 9'd255, '0);
    send_op(F_ERA, 9'd256, '0);
    send_op(F_FILL, 9'd257, '0);
    send_op(F_FILL, 9'd511, '0);
    send_op(F_FILL, 9'd0, '0);
  endtask

  // weighted random operations that keep the count moving over its whole range
  task automatic test_random_traffic(input int unsigned n, input bit gappy,
                                     input rx_pattern_t pattern);
    int unsigned i;
    int unsigned pick;
    int unsigned hi;
    tx_gappy   = gappy;
    rx_pattern = pattern;
    for (i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      hi   = (shadow_count == 0) ? 0 : shadow_count - 1;
      if (pick < 20) send_op(F_GET, pick_index(hi), pick_word());
      else if (pick < 32) send_op(F_SET, pick_index(hi), pick_word());
      else if (pick < 50) send_op(F_INS, pick_index(shadow_count), pick_word());
      else if (pick < 64) send_op(F_ERA, pick_index(shadow_count), pick_word());
      else if (pick < 75) send_op(F_PUSH, pick_index(DEPTH), pick_word());
      else if (pick < 85) send_op(F_POP, pick_index(DEPTH), pick_word());
      else if (pick < 88) send_op(F_CLEAR, pick_index(DEPTH), pick_word());
      else begin
        case ($urandom_range(0, 3))
          0:       send_op(F_FILL, INDEX_W'($urandom_range(0, 16)), pick_word());
          1:       send_op(F_FILL, INDEX_W'($urandom_range(DEPTH - 12, DEPTH)),
                           pick_word());
          default: send_op(F_FILL, INDEX_W'($urandom_range(0, DEPTH)), pick_word());
        endcase
      end
    end
  endtask

  // test sequence
  initial begin
    shadow_count   = 0;
    mismatch_count = 0;
    rx_pattern     = RX_READY;
    rx_tick        = 0;
    tx_gappy       = 1'b0;
    burst_left     = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    tx_gappy   = 1'b1;
    rx_pattern = RX_RANDOM;
    test_empty_array();
    rx_pattern = RX_PERIODIC;
    test_shift_ops();
    rx_pattern = RX_RANDOM;
    test_full_and_fill();
    test_random_traffic(100, 1'b0, RX_READY);
    test_random_traffic(200, 1'b1, RX_RANDOM);
    test_random_traffic(100, 1'b1, RX_PERIODIC);
    test_random_traffic(100, 1'b0, RX_HEAVY);

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) $display("shift_insert_array regression: pass");
    else $display("shift_insert_array regression: fail");
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("shift_insert_array regression: fail");
    $finish;
  end

endmodule

FILE: shift_insert_array.f
sv/sia_pkg.sv
sv/sia_cell.sv
sv/sia_rd_sel.sv
sv/shift_insert_array.sv
sim/tb_shift_insert_array.sv
